// File: hdl/whsp_pkg.sv
// whsp_pkg: word types, codes and header layout constants for the WAV header
// strip-and-parse block. No dependencies; used by every file in hdl/ but whsp_cell.
package whsp_pkg;

    // input word kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // output word kinds
    localparam logic RES_PAYLOAD = 1'b0;
    localparam logic RES_REPORT  = 1'b1;

    // header status codes
    localparam logic [1:0] STATUS_APPLIED     = 2'd0;
    localparam logic [1:0] STATUS_NO_PREAMBLE = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    // tags as little-endian 32-bit words: "RIFF", "WAVE", "fmt "
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;

    // PCM format code
    localparam logic [15:0] FORMAT_PCM = 16'd1;

    // byte offsets inside the header
    localparam int OFS_RIFF     = 0;
    localparam int OFS_WAVE     = 8;
    localparam int OFS_FMT      = 12;
    localparam int OFS_FORMAT   = 20;
    localparam int OFS_CHANNELS = 22;
    localparam int OFS_RATE     = 24;
    localparam int OFS_BITS     = 34;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [1:0]  header_status;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
    } t_out_word;

endpackage

// File: hdl/wav_header_strip_and_parse.sv
// wav_header_strip_and_parse: top level. Captures the WAV header in a chain
// of byte cells, reports its format, then passes payload bytes through.
// Depends on whsp_pkg, whsp_cell and whsp_report.
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_stall   whsp_pkg::t_in_word
//   out      output     o_out_valid / i_out_stall whsp_pkg::t_out_word
//
// One word in per cycle while o_in_stall is low.
// Header bytes shift down the cell chain; the last one completes the header
// and the report is built from the chain plus that byte in the same cycle.
// Reset and restart words clear the count and the done flag; no clearing pass.
// Output is an output register plus a skid register; o_in_stall is registered
// and rises only when both hold a word.
module wav_header_strip_and_parse #(
    parameter int HEADER_BYTES = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  whsp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output whsp_pkg::t_out_word o_out_word
);

    localparam int CELLS = HEADER_BYTES - 1;
    localparam int CNT_W = $clog2(HEADER_BYTES);

    logic [7:0]              cell_byte [CELLS];
    logic [HEADER_BYTES*8-1:0] hdr;
    whsp_pkg::t_out_word     report;
    whsp_pkg::t_out_word     new_word;

    logic             r_done,      n_done;
    logic [CNT_W-1:0] r_count,     n_count;
    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    whsp_pkg::t_out_word r_out_word, n_out_word;
    whsp_pkg::t_out_word r_skid_word, n_skid_word;

    logic in_acc, is_restart, hdr_byte, last_byte, produce, out_take;

    // input decode
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign is_restart = (i_in_word.kind == whsp_pkg::KIND_RESTART);
    assign hdr_byte   = in_acc && !is_restart && !r_done;
    assign last_byte  = hdr_byte && (r_count == CNT_W'(HEADER_BYTES - 1));
    assign produce    = in_acc && !is_restart && (r_done || last_byte);
    assign out_take   = r_out_valid && !i_out_stall;

    // capture chain: cell 0 takes the incoming byte
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            whsp_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (hdr_byte),
                .i_byte  (i_in_word.data_byte),
                .o_byte  (cell_byte[k])
            );
        end else begin : g_body
            whsp_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (hdr_byte),
                .i_byte  (cell_byte[k-1]),
                .o_byte  (cell_byte[k])
            );
        end
    end

    // header in byte order: offset j sits in cell CELLS-1-j, last offset is incoming
    for (genvar j = 0; j < HEADER_BYTES; j++) begin : g_hdr
        if (j == HEADER_BYTES - 1) begin : g_last
            assign hdr[8*j +: 8] = i_in_word.data_byte;
        end else begin : g_stored
            assign hdr[8*j +: 8] = cell_byte[CELLS-1-j];
        end
    end

    whsp_report #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_report (
        .i_hdr    (hdr),
        .o_report (report)
    );

    // result word: payload pass-through or the format report
    always_comb begin
        if (r_done) begin
            new_word              = '0;
            new_word.result_kind  = whsp_pkg::RES_PAYLOAD;
            new_word.payload_byte = i_in_word.data_byte;
        end else begin
            new_word = report;
        end
    end

    // header count and done flag
    always_comb begin
        n_count = r_count;
        n_done  = r_done;
        if (in_acc && is_restart) begin
            n_count = '0;
            n_done  = 1'b0;
        end else if (last_byte) begin
            n_done  = 1'b1;
        end else if (hdr_byte) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // output register and skid register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_skid_valid = r_skid_valid;
        n_skid_word  = r_skid_word;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out_word   = r_skid_word;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            n_out_valid = produce;
            if (produce) begin
                n_out_word = new_word;
            end
        end else if (produce) begin
            n_skid_valid = 1'b1;
            n_skid_word  = new_word;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done       <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_done       <= n_done;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // word registers
    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // skid only holds a word behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // the count parks on the last offset once the header is done
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_count == CNT_W'(HEADER_BYTES - 1)))
        else $error("header done with wrong count");

    // the last header byte always yields a word on the output side
    a_last_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_byte |=> r_out_valid)
        else $error("last header byte gave no report");

    // skid fills only while the output word is stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid ##1 r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid filled without output stall");

endmodule

// File: hdl/whsp_cell.sv
// whsp_cell: one byte cell of the header capture chain.
// Takes the neighbor's byte on each shift. Depends on nothing.
module whsp_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    // byte register, moves one cell down the chain per header byte
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: hdl/whsp_report.sv
// whsp_report: checks the RIFF/WAVE/fmt tags and extracts the PCM format
// fields from a complete header. Depends on whsp_pkg.
module whsp_report #(
    parameter int HEADER_BYTES = 44
) (
    input  logic [HEADER_BYTES*8-1:0] i_hdr,     // byte j at [8*j +: 8]
    output whsp_pkg::t_out_word       o_report
);

    logic        preamble_ok;
    logic [15:0] format_code;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic        fields_ok;

    // tag checks
    assign preamble_ok = (i_hdr[8*whsp_pkg::OFS_RIFF +: 32] == whsp_pkg::TAG_RIFF)
                      && (i_hdr[8*whsp_pkg::OFS_WAVE +: 32] == whsp_pkg::TAG_WAVE)
                      && (i_hdr[8*whsp_pkg::OFS_FMT  +: 32] == whsp_pkg::TAG_FMT);

    // little-endian fields, the header is already in byte order
    assign format_code = i_hdr[8*whsp_pkg::OFS_FORMAT   +: 16];
    assign channels    = i_hdr[8*whsp_pkg::OFS_CHANNELS +: 16];
    assign rate        = i_hdr[8*whsp_pkg::OFS_RATE     +: 32];
    assign bits        = i_hdr[8*whsp_pkg::OFS_BITS     +: 16];

    assign fields_ok = (format_code == whsp_pkg::FORMAT_PCM) && (channels != 16'd0)
                    && (rate != 32'd0) && (bits != 16'd0);

    // report word; numbers only when the header is applied
    always_comb begin
        o_report               = '0;
        o_report.result_kind   = whsp_pkg::RES_REPORT;
        if (!preamble_ok) begin
            o_report.header_status = whsp_pkg::STATUS_NO_PREAMBLE;
        end else if (!fields_ok) begin
            o_report.header_status = whsp_pkg::STATUS_UNSUPPORTED;
        end else begin
            o_report.header_status = whsp_pkg::STATUS_APPLIED;
            o_report.sample_rate   = rate;
            o_report.channel_count = channels;
            o_report.sample_bits   = bits;
        end
    end

endmodule

// File: tb/whsp_stream_check.sv
// whsp_stream_check: watches both channels of wav_header_strip_and_parse, predicts
// every output word from the accepted input words and compares. Depends on whsp_pkg.
module whsp_stream_check #(
    parameter int HEADER_BYTES = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  whsp_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  whsp_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending
);
    import whsp_pkg::*;

    // predicted parser state
    logic [7:0] hdr_bytes [HEADER_BYTES];
    int         hdr_count;
    logic       hdr_done;

    t_out_word  expected_words [$];
    int         fail_count;

    function automatic logic [15:0] hdr_le16(input int pos);
        return {hdr_bytes[pos + 1], hdr_bytes[pos]};
    endfunction

    function automatic logic [31:0] hdr_le32(input int pos);
        return {hdr_le16(pos + 2), hdr_le16(pos)};
    endfunction

    task automatic clear_capture();
        hdr_count = 0;
        hdr_done  = 1'b0;
        foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
    endtask

    // build the report for a complete header
    function automatic t_out_word format_report();
        t_out_word   rep;
        logic [15:0] fmt;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        rep             = '0;
        rep.result_kind = RES_REPORT;
        fmt   = hdr_le16(OFS_FORMAT);
        chans = hdr_le16(OFS_CHANNELS);
        rate  = hdr_le32(OFS_RATE);
        bits  = hdr_le16(OFS_BITS);
        if (hdr_le32(OFS_RIFF) != TAG_RIFF || hdr_le32(OFS_WAVE) != TAG_WAVE ||
            hdr_le32(OFS_FMT) != TAG_FMT) begin
            rep.header_status = STATUS_NO_PREAMBLE;
        end else if (fmt != FORMAT_PCM || chans == '0 || rate == '0 || bits == '0) begin
            rep.header_status = STATUS_UNSUPPORTED;
        end else begin
            rep.header_status = STATUS_APPLIED;
            rep.sample_rate   = rate;
            rep.channel_count = chans;
            rep.sample_bits   = bits;
        end
        return rep;
    endfunction

    // advance the prediction by one accepted input word
    task automatic take_word(input t_in_word w);
        t_out_word res;
        res = '0;
        if (w.kind == KIND_RESTART) begin
            clear_capture();
        end else if (hdr_done) begin
            res.result_kind  = RES_PAYLOAD;
            res.payload_byte = w.data_byte;
            expected_words.push_back(res);
        end else begin
            hdr_bytes[hdr_count] = w.data_byte;
            hdr_count++;
            if (hdr_count == HEADER_BYTES) begin
                hdr_done = 1'b1;
                expected_words.push_back(format_report());
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp,
                                 input logic [31:0] act);
        if (act !== exp) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
            fail_count++;
        end
    endtask

    task automatic check_word(input t_out_word act);
        t_out_word exp;
        if (expected_words.size() == 0) begin
            $display("%0t: output word with none expected: expected none, actual %h",
                     $time, act);
            fail_count++;
        end else begin
            exp = expected_words.pop_front();
            compare_field("result_kind", 32'(exp.result_kind), 32'(act.result_kind));
            compare_field("payload_byte", 32'(exp.payload_byte), 32'(act.payload_byte));
            compare_field("header_status", 32'(exp.header_status),
                          32'(act.header_status));
            compare_field("sample_rate", exp.sample_rate, act.sample_rate);
            compare_field("channel_count", 32'(exp.channel_count),
                          32'(act.channel_count));
            compare_field("sample_bits", 32'(exp.sample_bits), 32'(act.sample_bits));
        end
    endtask

    // outputs are checked before inputs: a result never leaves in its own cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_capture();
            expected_words.delete();
            fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) check_word(i_out_word);
            if (i_in_valid && !i_in_stall) take_word(i_in_word);
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: tb/wav_header_strip_and_parse_tb.sv
// wav_header_strip_and_parse_tb: drives WAV streams (good, broken and noisy headers
// with payload) into the block with random gaps and stalls. Depends on whsp_pkg,
// whsp_stream_check and the RTL.
module wav_header_strip_and_parse_tb;
    import whsp_pkg::*;

    localparam int HEADER_BYTES = 44;
    localparam int ITEM_TARGET  = 1050;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {
        HDR_GOOD,
        HDR_BAD_TAG,
        HDR_BAD_FORMAT,
        HDR_NO_CHANNELS,
        HDR_NO_RATE,
        HDR_NO_BITS,
        HDR_NOISE
    } t_hdr_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int        fail_count;
    int        pending;
    logic      quiet     = 1'b0;
    int        sent      = 0;
    logic [7:0] hdr_img [HEADER_BYTES];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    wav_header_strip_and_parse #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    whsp_stream_check #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stalls at random, except in the quiet stretch
    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 23);
    end

    // hand one word over, with random idle cycles ahead of it
    task automatic send_word(input logic kind, input logic [7:0] data);
        t_in_word w;
        w.kind      = kind;
        w.data_byte = data;
        if (!quiet) begin
            while ($urandom_range(99) < 23) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic put16(input int pos, input logic [15:0] val);
        hdr_img[pos]     = val[7:0];
        hdr_img[pos + 1] = val[15:8];
    endtask

    task automatic put32(input int pos, input logic [31:0] val);
        put16(pos, val[15:0]);
        put16(pos + 2, val[31:16]);
    endtask

    // fill hdr_img with a header of the given flavor
    task automatic build_header(input t_hdr_mode mode);
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [15:0] fmt;
        int          pos;
        foreach (hdr_img[i]) hdr_img[i] = 8'($urandom);
        if (mode == HDR_NOISE) return;
        put32(OFS_RIFF, TAG_RIFF);
        put32(OFS_WAVE, TAG_WAVE);
        put32(OFS_FMT, TAG_FMT);
        put16(OFS_FORMAT, FORMAT_PCM);
        chans = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
        rate  = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(8000, 192000));
        bits  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(8 * $urandom_range(1, 4));
        if (chans == '0) chans = 16'd1;
        if (rate == '0) rate = 32'd1;
        if (bits == '0) bits = 16'd1;
        put16(OFS_CHANNELS, chans);
        put32(OFS_RATE, rate);
        put16(OFS_BITS, bits);
        case (mode)
            HDR_BAD_TAG: begin
                case ($urandom_range(2))
                    0:       pos = OFS_RIFF;
                    1:       pos = OFS_WAVE;
                    default: pos = OFS_FMT;
                endcase
                pos          = pos + $urandom_range(3);
                hdr_img[pos] = hdr_img[pos] ^ 8'($urandom_range(1, 255));
                // a broken preamble must win over a bad format
                if ($urandom_range(2) == 0) put16(OFS_FORMAT, 16'd0);
            end
            HDR_BAD_FORMAT: begin
                fmt = 16'($urandom);
                if ($urandom_range(3) == 0) fmt = 16'd0;
                if (fmt == FORMAT_PCM) fmt = 16'hFFFF;
                put16(OFS_FORMAT, fmt);
            end
            HDR_NO_CHANNELS: put16(OFS_CHANNELS, 16'd0);
            HDR_NO_RATE:     put32(OFS_RATE, 32'd0);
            HDR_NO_BITS:     put16(OFS_BITS, 16'd0);
            default: ;
        endcase
    endtask

    task automatic send_header(input int count);
        for (int i = 0; i < count; i++) send_word(KIND_DATA, hdr_img[i]);
    endtask

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_hdr_mode mode;
        int        n_pay;
        int        cut;
        int        pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header straight after reset, all numeric fields at their maximum
        build_header(HDR_GOOD);
        put32(OFS_RATE, '1);
        put16(OFS_CHANNELS, '1);
        put16(OFS_BITS, '1);
        send_header(HEADER_BYTES);
        send_word(KIND_DATA, 8'h00);
        send_word(KIND_DATA, 8'hFF);
        send_word(KIND_DATA, 8'h5A);
        send_word(KIND_DATA, 8'hA5);
        send_word(KIND_RESTART, 8'hFF);

        // minimum legal fields, rate only in its top byte
        build_header(HDR_GOOD);
        put32(OFS_RATE, 32'h0100_0000);
        put16(OFS_CHANNELS, 16'd1);
        put16(OFS_BITS, 16'd1);
        send_header(HEADER_BYTES);
        send_word(KIND_DATA, 8'h80);
        send_word(KIND_RESTART, 8'h00);

        // restart part way through a header, then back to back restarts
        build_header(HDR_GOOD);
        send_header(10);
        send_word(KIND_RESTART, 8'h55);
        send_word(KIND_RESTART, 8'hAA);
        put32(OFS_RATE, 32'd1);
        send_header(HEADER_BYTES);
        send_word(KIND_DATA, 8'h01);

        // random streams: under half well formed, the rest broken, some cut short or garbled
        while (sent < ITEM_TARGET) begin
            quiet = (sent > 350 && sent < 560);
            send_word(KIND_RESTART, 8'($urandom));
            pick = $urandom_range(11);
            case (pick)
                0, 1, 2, 3, 4: mode = HDR_GOOD;
                5:             mode = HDR_BAD_TAG;
                6:             mode = HDR_BAD_FORMAT;
                7:             mode = HDR_NO_CHANNELS;
                8:             mode = HDR_NO_RATE;
                9:             mode = HDR_NO_BITS;
                10:            mode = HDR_NOISE;
                default:       mode = HDR_BAD_TAG;
            endcase
            build_header(mode);
            cut = ($urandom_range(9) == 0) ? $urandom_range(HEADER_BYTES - 1) : HEADER_BYTES;
            send_header(cut);
            if (cut == HEADER_BYTES) begin
                n_pay = $urandom_range(40);
                repeat (n_pay) send_word(KIND_DATA, 8'($urandom));
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // let the last word reach the checker, then drain
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
